// ----- design/olid_pkg.sv -----
// shared types and constants for the ordered list block
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package olid_pkg;

    localparam int CAPACITY = 16;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int LETTER_W = 8;
    localparam int AMOUNT_W = 32;
    localparam int ENTRY_W  = LETTER_W + AMOUNT_W;
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CMP_W-1:0]  cmp_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SHOW   = 2'd2,
        CMD_INSERT = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 3'd0,
        ST_SHOWN  = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_BEYOND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_ZERO = 3'd1,
        IDX_LEN  = 3'd2,
        IDX_INC  = 3'd3,
        IDX_DEC  = 3'd4
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_SHIFT = 2'd1,
        WR_NEW   = 2'd2
    } wr_op_t;

    typedef enum logic [1:0] {
        LEN_HOLD = 2'd0,
        LEN_INC  = 2'd1,
        LEN_DEC  = 2'd2
    } len_op_t;

    typedef struct packed {
        logic    load_item;
        idx_op_t idx_op;
        logic    rd_prev;
        wr_op_t  wr_op;
        len_op_t len_op;
        logic    emit;
        status_t emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic beyond;
        logic idx_at_pos;
        logic show_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/olid_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module olid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/olid_datapath.sv -----
// datapath: entry ram, length and index registers, command capture, result register
// depends on olid_pkg and olid_ram
`timescale 1ns / 1ps

module olid_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  olid_pkg::ctrl_cmd_t                     ctrl,
    output olid_pkg::dp_status_t                    status,
    input  logic [olid_pkg::CMD_W-1:0]              in_command,
    input  logic [olid_pkg::POS_W-1:0]              in_position,
    input  logic [olid_pkg::LETTER_W-1:0]           in_letter,
    input  logic signed [olid_pkg::AMOUNT_W-1:0]    in_amount,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic [olid_pkg::STATUS_W-1:0]           out_status,
    output logic [olid_pkg::LETTER_W-1:0]           out_letter,
    output logic signed [olid_pkg::AMOUNT_W-1:0]    out_amount,
    output logic                                    out_last
);

    olid_pkg::cmd_t                          cmd_reg;
    logic [olid_pkg::POS_W-1:0]              pos_reg;
    logic [olid_pkg::LETTER_W-1:0]           letter_reg;
    logic signed [olid_pkg::AMOUNT_W-1:0]    amount_reg;

    olid_pkg::len_t len_reg, len_next;
    olid_pkg::len_t idx_reg, idx_next;
    olid_pkg::len_t idx_m1;
    olid_pkg::len_t idx_p1;

    logic                                    out_valid_reg;
    logic [olid_pkg::STATUS_W-1:0]           out_status_reg;
    logic [olid_pkg::LETTER_W-1:0]           out_letter_reg;
    logic signed [olid_pkg::AMOUNT_W-1:0]    out_amount_reg;
    logic                                    out_last_reg;

    logic                                    wr_en;
    olid_pkg::addr_t                         wr_addr;
    logic [olid_pkg::ENTRY_W-1:0]            wr_data;
    olid_pkg::addr_t                         rd_addr;
    logic [olid_pkg::ENTRY_W-1:0]            rd_data;
    logic                                    show_last;
    logic                                    shown;

    assign idx_m1 = idx_reg - olid_pkg::len_t'(1);
    assign idx_p1 = idx_reg + olid_pkg::len_t'(1);
    assign show_last = (idx_p1 == len_reg);

    // entry word: letter in the high bits, amount in the low bits
    assign rd_addr = ctrl.rd_prev ? idx_m1[olid_pkg::ADDR_W-1:0]
                                  : idx_reg[olid_pkg::ADDR_W-1:0];
    assign wr_addr = idx_reg[olid_pkg::ADDR_W-1:0];
    assign wr_en   = (ctrl.wr_op != olid_pkg::WR_NONE);
    assign wr_data = (ctrl.wr_op == olid_pkg::WR_SHIFT) ? rd_data
                                                         : {letter_reg, amount_reg};

    olid_ram #(
        .WIDTH (olid_pkg::ENTRY_W),
        .DEPTH (olid_pkg::CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg    <= olid_pkg::cmd_t'(in_command);
            pos_reg    <= in_position;
            letter_reg <= in_letter;
            amount_reg <= in_amount;
        end
    end

    always_comb
    begin
        case (ctrl.len_op)
            olid_pkg::LEN_INC: len_next = len_reg + olid_pkg::len_t'(1);
            olid_pkg::LEN_DEC: len_next = len_reg - olid_pkg::len_t'(1);
            default:           len_next = len_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.idx_op)
            olid_pkg::IDX_ZERO: idx_next = '0;
            olid_pkg::IDX_LEN:  idx_next = len_reg;
            olid_pkg::IDX_INC:  idx_next = idx_p1;
            olid_pkg::IDX_DEC:  idx_next = idx_m1;
            default:            idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            idx_reg <= idx_next;
        end
    end

    assign shown = (ctrl.emit_status == olid_pkg::ST_SHOWN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_status_reg <= ctrl.emit_status;
            out_letter_reg <= shown ? rd_data[olid_pkg::ENTRY_W-1:olid_pkg::AMOUNT_W] : '0;
            out_amount_reg <= shown ? rd_data[olid_pkg::AMOUNT_W-1:0] : '0;
            out_last_reg   <= shown ? show_last : 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_letter = out_letter_reg;
    assign out_amount = out_amount_reg;
    assign out_last   = out_last_reg;

    assign status.cmd        = cmd_reg;
    assign status.full       = (len_reg == olid_pkg::len_t'(olid_pkg::CAPACITY));
    assign status.empty      = (len_reg == '0);
    assign status.beyond     = (olid_pkg::cmp_t'(pos_reg) > olid_pkg::cmp_t'(len_reg));
    assign status.idx_at_pos = (olid_pkg::cmp_t'(idx_reg) == olid_pkg::cmp_t'(pos_reg));
    assign status.show_last  = show_last;
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

// ----- design/olid_controller.sv -----
// controller state machine: decodes a command and sequences the datapath
// depends on olid_pkg
`timescale 1ns / 1ps

module olid_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  olid_pkg::dp_status_t status,
    output olid_pkg::ctrl_cmd_t  ctrl
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_SHIFT_CK = 8'b0000_0100,
        S_SHIFT_WR = 8'b0000_1000,
        S_WRITE    = 8'b0001_0000,
        S_DONE     = 8'b0010_0000,
        S_SHOW_RD  = 8'b0100_0000,
        S_SHOW_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        ctrl.load_item   = 1'b0;
        ctrl.idx_op      = olid_pkg::IDX_HOLD;
        ctrl.rd_prev     = 1'b0;
        ctrl.wr_op       = olid_pkg::WR_NONE;
        ctrl.len_op      = olid_pkg::LEN_HOLD;
        ctrl.emit        = 1'b0;
        ctrl.emit_status = olid_pkg::ST_DONE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_DECODE;
                end
            end

            // error results wait here until the result register is free
            S_DECODE:
            begin
                case (status.cmd)
                    olid_pkg::CMD_APPEND:
                    begin
                        if (status.full)
                        begin
                            ctrl.emit_status = olid_pkg::ST_FULL;
                            if (status.out_free)
                            begin
                                ctrl.emit  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctrl.idx_op = olid_pkg::IDX_LEN;
                            state_next  = S_WRITE;
                        end
                    end

                    olid_pkg::CMD_DELETE:
                    begin
                        if (status.empty)
                        begin
                            ctrl.emit_status = olid_pkg::ST_EMPTY;
                            if (status.out_free)
                            begin
                                ctrl.emit  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctrl.len_op = olid_pkg::LEN_DEC;
                            state_next  = S_DONE;
                        end
                    end

                    olid_pkg::CMD_SHOW:
                    begin
                        if (status.empty)
                        begin
                            ctrl.emit_status = olid_pkg::ST_EMPTY;
                            if (status.out_free)
                            begin
                                ctrl.emit  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctrl.idx_op = olid_pkg::IDX_ZERO;
                            state_next  = S_SHOW_RD;
                        end
                    end

                    default:
                    begin
                        if (status.full || status.beyond)
                        begin
                            ctrl.emit_status = status.full ? olid_pkg::ST_FULL
                                                           : olid_pkg::ST_BEYOND;
                            if (status.out_free)
                            begin
                                ctrl.emit  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctrl.idx_op = olid_pkg::IDX_LEN;
                            state_next  = S_SHIFT_CK;
                        end
                    end
                endcase
            end

            // move entries back one slot from the tail down to the insert position
            S_SHIFT_CK:
            begin
                if (status.idx_at_pos)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    ctrl.rd_prev = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                ctrl.wr_op  = olid_pkg::WR_SHIFT;
                ctrl.idx_op = olid_pkg::IDX_DEC;
                state_next  = S_SHIFT_CK;
            end

            S_WRITE:
            begin
                ctrl.wr_op  = olid_pkg::WR_NEW;
                ctrl.len_op = olid_pkg::LEN_INC;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                ctrl.emit_status = olid_pkg::ST_DONE;
                if (status.out_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SHOW_RD:
            begin
                state_next = S_SHOW_OUT;
            end

            // read address is held, so ram data stays valid while stalled
            S_SHOW_OUT:
            begin
                ctrl.emit_status = olid_pkg::ST_SHOWN;
                if (status.out_free)
                begin
                    ctrl.emit = 1'b1;
                    if (status.show_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl.idx_op = olid_pkg::IDX_INC;
                        state_next  = S_SHOW_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ordered_list_insert_delete_top.sv -----
// top level of the bounded ordered list: stream ports, controller and datapath
// depends on olid_pkg, olid_controller, olid_datapath
// sequence: append writes at the length, delete drops the tail entry, errors go out
//   at decode, insert shifts then writes, show per entry: ram read, then result register
// throughput: one command at a time; the next is taken when the sequencer returns to idle,
//   while the last result may still wait in the output register
// reset: rst_n clears the length, index, sequencer and result valid; the entry ram is not
//   cleared, entries at or past the length are never read
`timescale 1ns / 1ps

module ordered_list_insert_delete_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // position[4:0], letter[12:5], amount[44:13], zero pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_letter[7:0], out_amount[39:8]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    olid_pkg::ctrl_cmd_t  ctrl;
    olid_pkg::dp_status_t status;

    logic [olid_pkg::LETTER_W-1:0]        out_letter;
    logic signed [olid_pkg::AMOUNT_W-1:0] out_amount;

    olid_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    olid_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_command  (s_tuser),
        .in_position (s_tdata[4:0]),
        .in_letter   (s_tdata[12:5]),
        .in_amount   (s_tdata[44:13]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_letter  (out_letter),
        .out_amount  (out_amount),
        .out_last    (m_tlast)
    );

    assign m_tdata = {out_amount, out_letter};

endmodule
